// ===== hw/rtl/dmtlb_pkg.sv =====
package dmtlb_pkg;

    localparam int ENTRIES    = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int VA_BITS    = 48;
    localparam int FRAME_BITS = 28;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int TAG_W  = VA_BITS - PAGE_SHIFT;
    localparam int LIM_W  = VA_BITS + 1;
    localparam int LAST_W = LIM_W - PAGE_SHIFT + 1;
    localparam int PROT_W = 8;
    localparam int FLAG_W = 8;
    localparam int CTR_W  = 32;
    localparam int KIND_W = 3;
    localparam int OUT_W  = 2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1) << (VA_BITS - 1);

    localparam logic [KIND_W-1:0] KIND_LOOKUP = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_INSERT = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_INVPG  = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_RANGE  = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_FLUSH  = KIND_W'(4);

    typedef enum logic [OUT_W-1:0] {
        OUT_DONE,
        OUT_MISS,
        OUT_STALE,
        OUT_REJECT
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]      tag;
        logic [FRAME_BITS-1:0] frame;
        logic [PROT_W-1:0]     prot;
        logic [FLAG_W-1:0]     flags;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [IDX_W-1:0] slot_of(input logic [TAG_W-1:0] page);
        return IDX_W'(page % TAG_W'(ENTRIES));
    endfunction

endpackage

// ===== hw/rtl/dmtlb_ram.sv =====
module dmtlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/direct_mapped_tlb_core.sv =====
// channel   direction  handshake                 beat
// cfg       in         i_cfg_we                  i_cfg_data (user address limit)
// request   in         i_in_valid / o_in_stall   i_kind .. i_frame_resident
// result    out        o_out_valid / i_out_stall o_outcome .. o_invalidate_count
//
// Lookup, insert, invalidate page and rejected items go from accept to S_EXEC, which
// uses the registered read of the entry RAM. Range invalidation and flush walk
// every entry through the RAM read port in S_WALK, then finish in S_DONE.
// One item in flight; the result register frees the request side while a beat waits.
// Reset invalidates all entries at once (valid bits in flops), no clearing pass.
module direct_mapped_tlb_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dmtlb_pkg::LIM_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dmtlb_pkg::KIND_W-1:0]      i_kind,
    input  logic [dmtlb_pkg::VA_BITS-1:0]     i_address,
    input  logic [dmtlb_pkg::LIM_W-1:0]       i_end_address,
    input  logic [dmtlb_pkg::FRAME_BITS-1:0]  i_frame_number,
    input  logic [dmtlb_pkg::PROT_W-1:0]      i_protection,
    input  logic [dmtlb_pkg::FLAG_W-1:0]      i_page_flags,
    input  logic                              i_frame_resident,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dmtlb_pkg::OUT_W-1:0]       o_outcome,
    output logic [dmtlb_pkg::FRAME_BITS-1:0]  o_hit_frame,
    output logic [dmtlb_pkg::PROT_W-1:0]      o_hit_protection,
    output logic [dmtlb_pkg::FLAG_W-1:0]      o_hit_flags,
    output logic [dmtlb_pkg::CTR_W-1:0]       o_hit_count,
    output logic [dmtlb_pkg::CTR_W-1:0]       o_miss_count,
    output logic [dmtlb_pkg::CTR_W-1:0]       o_replace_count,
    output logic [dmtlb_pkg::CTR_W-1:0]       o_invalidate_count
);

    import dmtlb_pkg::*;

    t_state               r_state, n_state;
    logic [LIM_W-1:0]     r_limit;
    logic [ENTRIES-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_chk_v, n_chk_v;
    logic [IDX_W-1:0]     r_chk_idx, n_chk_idx;
    logic [CTR_W-1:0]     r_hits, n_hits;
    logic [CTR_W-1:0]     r_misses, n_misses;
    logic [CTR_W-1:0]     r_repl, n_repl;
    logic [CTR_W-1:0]     r_inv, n_inv;

    logic [KIND_W-1:0]     r_kind;
    logic [VA_BITS-1:0]    r_addr;
    logic [LIM_W-1:0]      r_end;
    logic [LAST_W-1:0]     r_last;
    logic [FRAME_BITS-1:0] r_frame;
    logic [PROT_W-1:0]     r_prot;
    logic [FLAG_W-1:0]     r_flags;
    logic                  r_res;

    logic                  r_out_valid, n_out_valid;
    t_outcome              r_out_outcome, n_out_outcome;
    logic [FRAME_BITS-1:0] r_out_frame, n_out_frame;
    logic [PROT_W-1:0]     r_out_prot, n_out_prot;
    logic [FLAG_W-1:0]     r_out_flags, n_out_flags;
    logic [CTR_W-1:0]      r_out_hits, n_out_hits;
    logic [CTR_W-1:0]      r_out_misses, n_out_misses;
    logic [CTR_W-1:0]      r_out_repl, n_out_repl;
    logic [CTR_W-1:0]      r_out_inv, n_out_inv;

    logic              in_accept;
    logic              out_free;
    logic              load;
    logic [TAG_W-1:0]  page;
    logic [IDX_W-1:0]  slot;
    logic              ent_valid;
    logic              tag_eq;
    logic              over;
    logic              range_bad;
    logic              in_span;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    t_entry            ram_wdata;
    t_entry            rd;

    dmtlb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign page      = r_addr[VA_BITS-1:PAGE_SHIFT];
    assign slot      = slot_of(page);
    assign ent_valid = r_valid[slot];
    assign tag_eq    = (rd.tag == page);
    assign over      = ({1'b0, r_addr} >= r_limit);
    assign range_bad = ({1'b0, r_addr} >= r_end) || (r_end > r_limit);
    assign in_span   = (LAST_W'(rd.tag) >= LAST_W'(page)) && (LAST_W'(rd.tag) < r_last);

    assign ram_wdata = '{tag: page, frame: r_frame, prot: r_prot, flags: r_flags};

    always_comb begin
        case (r_state)
            S_IDLE:  ram_raddr = slot_of(i_address[VA_BITS-1:PAGE_SHIFT]);
            S_WALK:  ram_raddr = r_idx[IDX_W-1:0];
            default: ram_raddr = slot;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_idx         = r_idx;
        n_chk_v       = r_chk_v;
        n_chk_idx     = r_chk_idx;
        n_hits        = r_hits;
        n_misses      = r_misses;
        n_repl        = r_repl;
        n_inv         = r_inv;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_outcome = r_out_outcome;
        n_out_frame   = r_out_frame;
        n_out_prot    = r_out_prot;
        n_out_flags   = r_out_flags;
        ram_we        = 1'b0;
        load          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((r_kind == KIND_RANGE && !range_bad) || r_kind == KIND_FLUSH) begin
                    n_state = S_WALK;
                    n_idx   = '0;
                    n_chk_v = 1'b0;
                end else if (out_free) begin
                    load          = 1'b1;
                    n_state       = S_IDLE;
                    n_out_outcome = OUT_DONE;
                    n_out_frame   = '0;
                    n_out_prot    = '0;
                    n_out_flags   = '0;
                    case (r_kind)
                        KIND_LOOKUP: begin
                            if (over) begin
                                n_out_outcome = OUT_REJECT;
                            end else if (!(ent_valid && tag_eq)) begin
                                n_misses      = r_misses + 1'b1;
                                n_out_outcome = OUT_MISS;
                            end else if (!r_res) begin
                                n_valid[slot] = 1'b0;
                                n_inv         = r_inv + 1'b1;
                                n_misses      = r_misses + 1'b1;
                                n_out_outcome = OUT_STALE;
                            end else begin
                                n_hits      = r_hits + 1'b1;
                                n_out_frame = rd.frame;
                                n_out_prot  = rd.prot;
                                n_out_flags = rd.flags;
                            end
                        end
                        KIND_INSERT: begin
                            if (over) begin
                                n_out_outcome = OUT_REJECT;
                            end else begin
                                if (ent_valid && !tag_eq) begin
                                    n_repl = r_repl + 1'b1;
                                end
                                ram_we        = 1'b1;
                                n_valid[slot] = 1'b1;
                            end
                        end
                        KIND_INVPG: begin
                            if (over) begin
                                n_out_outcome = OUT_REJECT;
                            end else if (ent_valid && tag_eq) begin
                                n_valid[slot] = 1'b0;
                                n_inv         = r_inv + 1'b1;
                            end
                        end
                        default: begin
                            n_out_outcome = OUT_REJECT;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_idx != CNT_W'(ENTRIES)) begin
                    n_idx     = r_idx + 1'b1;
                    n_chk_v   = 1'b1;
                    n_chk_idx = r_idx[IDX_W-1:0];
                end else begin
                    n_chk_v = 1'b0;
                end
                if (r_chk_v) begin
                    if (r_valid[r_chk_idx] && (r_kind == KIND_FLUSH || in_span)) begin
                        n_valid[r_chk_idx] = 1'b0;
                        n_inv              = r_inv + 1'b1;
                    end
                    if (r_chk_idx == IDX_W'(ENTRIES - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load          = 1'b1;
                    n_state       = S_IDLE;
                    n_out_outcome = OUT_DONE;
                    n_out_frame   = '0;
                    n_out_prot    = '0;
                    n_out_flags   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end
        n_out_hits   = load ? n_hits   : r_out_hits;
        n_out_misses = load ? n_misses : r_out_misses;
        n_out_repl   = load ? n_repl   : r_out_repl;
        n_out_inv    = load ? n_inv    : r_out_inv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_valid     <= '0;
            r_idx       <= '0;
            r_chk_v     <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_repl      <= '0;
            r_inv       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= i_cfg_we ? i_cfg_data : r_limit;
            r_valid     <= n_valid;
            r_idx       <= n_idx;
            r_chk_v     <= n_chk_v;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_repl      <= n_repl;
            r_inv       <= n_inv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_kind;
            r_addr  <= i_address;
            r_end   <= i_end_address;
            r_last  <= LAST_W'(i_end_address >> PAGE_SHIFT)
                     + LAST_W'(|i_end_address[PAGE_SHIFT-1:0]);
            r_frame <= i_frame_number;
            r_prot  <= i_protection;
            r_flags <= i_page_flags;
            r_res   <= i_frame_resident;
        end
        r_chk_idx     <= n_chk_idx;
        r_out_outcome <= n_out_outcome;
        r_out_frame   <= n_out_frame;
        r_out_prot    <= n_out_prot;
        r_out_flags   <= n_out_flags;
        r_out_hits    <= n_out_hits;
        r_out_misses  <= n_out_misses;
        r_out_repl    <= n_out_repl;
        r_out_inv     <= n_out_inv;
    end

    assign o_out_valid        = r_out_valid;
    assign o_outcome          = r_out_outcome;
    assign o_hit_frame        = r_out_frame;
    assign o_hit_protection   = r_out_prot;
    assign o_hit_flags        = r_out_flags;
    assign o_hit_count        = r_out_hits;
    assign o_miss_count       = r_out_misses;
    assign o_replace_count    = r_out_repl;
    assign o_invalidate_count = r_out_inv;

    a_we_insert_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_EXEC) && (r_kind == KIND_INSERT))
        else $error("entry RAM written outside an insert");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && r_chk_v && (r_chk_idx == IDX_W'(ENTRIES - 1))
        |=> (r_state == S_DONE))
        else $error("entry walk did not finish after last entry");

    a_chk_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_v |-> (r_state == S_WALK))
        else $error("walk check pending outside walk");

    a_miss_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome != OUT_DONE)
        |-> (o_hit_frame == '0) && (o_hit_protection == '0) && (o_hit_flags == '0))
        else $error("entry data shown on a non-hit result");

    a_load_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_invalidate_count == r_inv) && (o_hit_count == r_hits))
        else $error("result counters differ from running counters");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

import dmtlb_pkg::*;

typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [VA_BITS-1:0]    addr;
    logic [LIM_W-1:0]      end_addr;
    logic [FRAME_BITS-1:0] frame;
    logic [PROT_W-1:0]     prot;
    logic [FLAG_W-1:0]     flags;
    logic                  resident;
} t_tlb_req;

typedef struct {
    logic [OUT_W-1:0]      outcome;
    logic [FRAME_BITS-1:0] frame;
    logic [PROT_W-1:0]     prot;
    logic [FLAG_W-1:0]     flags;
    logic [CTR_W-1:0]      hits;
    logic [CTR_W-1:0]      misses;
    logic [CTR_W-1:0]      replacements;
    logic [CTR_W-1:0]      invalidations;
} t_tlb_rsp;

class t_tlb_scoreboard;
    logic [LIM_W-1:0]      user_limit;
    bit                    slot_valid [ENTRIES];
    logic [TAG_W-1:0]      slot_tag   [ENTRIES];
    logic [FRAME_BITS-1:0] slot_frame [ENTRIES];
    logic [PROT_W-1:0]     slot_prot  [ENTRIES];
    logic [FLAG_W-1:0]     slot_flags [ENTRIES];
    logic [CTR_W-1:0]      hits;
    logic [CTR_W-1:0]      misses;
    logic [CTR_W-1:0]      replacements;
    logic [CTR_W-1:0]      invalidations;
    t_tlb_rsp              awaited[$];
    int                    failures;

    function new();
        user_limit = LIMIT_RESET;
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_tag[i]   = '0;
            slot_frame[i] = '0;
            slot_prot[i]  = '0;
            slot_flags[i] = '0;
        end
        hits          = '0;
        misses        = '0;
        replacements  = '0;
        invalidations = '0;
        failures      = 0;
    endfunction

    function void set_limit(logic [LIM_W-1:0] value);
        user_limit = value;
    endfunction

    function void drop_slot(int s);
        slot_valid[s] = 1'b0;
        invalidations++;
    endfunction

    function void note_request(t_tlb_req r);
        t_tlb_rsp         e;
        logic [TAG_W-1:0] page;
        int               s;
        logic [63:0]      span_first;
        logic [63:0]      end_page;
        e = '{default: '0};
        e.outcome = OUT_DONE;
        page = r.addr[VA_BITS-1:PAGE_SHIFT];
        s = int'(page % ENTRIES);
        case (r.kind)
            KIND_LOOKUP: begin
                if (r.addr >= user_limit) begin
                    e.outcome = OUT_REJECT;
                end else if (!slot_valid[s] || slot_tag[s] != page) begin
                    misses++;
                    e.outcome = OUT_MISS;
                end else if (!r.resident) begin
                    drop_slot(s);
                    misses++;
                    e.outcome = OUT_STALE;
                end else begin
                    hits++;
                    e.frame = slot_frame[s];
                    e.prot  = slot_prot[s];
                    e.flags = slot_flags[s];
                end
            end
            KIND_INSERT: begin
                if (r.addr >= user_limit) begin
                    e.outcome = OUT_REJECT;
                end else begin
                    if (slot_valid[s] && slot_tag[s] != page)
                        replacements++;
                    slot_tag[s]   = page;
                    slot_frame[s] = r.frame;
                    slot_prot[s]  = r.prot;
                    slot_flags[s] = r.flags;
                    slot_valid[s] = 1'b1;
                end
            end
            KIND_INVPG: begin
                if (r.addr >= user_limit)
                    e.outcome = OUT_REJECT;
                else if (slot_valid[s] && slot_tag[s] == page)
                    drop_slot(s);
            end
            KIND_RANGE: begin
                if (LIM_W'(r.addr) >= r.end_addr || r.end_addr > user_limit) begin
                    e.outcome = OUT_REJECT;
                end else begin
                    // end is exclusive and rounds up to the next page
                    span_first = 64'(r.addr) >> PAGE_SHIFT;
                    end_page = (64'(r.end_addr) + (64'(1) << PAGE_SHIFT) - 64'(1))
                               >> PAGE_SHIFT;
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_valid[i] && 64'(slot_tag[i]) >= span_first &&
                            64'(slot_tag[i]) < end_page)
                            drop_slot(i);
                end
            end
            KIND_FLUSH: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_valid[i])
                        drop_slot(i);
            end
            default: e.outcome = OUT_REJECT;
        endcase
        e.hits          = hits;
        e.misses        = misses;
        e.replacements  = replacements;
        e.invalidations = invalidations;
        awaited.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    function void check_result(t_tlb_rsp got);
        t_tlb_rsp e;
        if (awaited.size() == 0) begin
            failures++;
            $display("%0t unexpected beat: expected none, got outcome %0d",
                     $time, got.outcome);
            return;
        end
        e = awaited.pop_front();
        compare_field("outcome", 64'(e.outcome), 64'(got.outcome));
        compare_field("hit_frame", 64'(e.frame), 64'(got.frame));
        compare_field("hit_protection", 64'(e.prot), 64'(got.prot));
        compare_field("hit_flags", 64'(e.flags), 64'(got.flags));
        compare_field("hit_count", 64'(e.hits), 64'(got.hits));
        compare_field("miss_count", 64'(e.misses), 64'(got.misses));
        compare_field("replace_count", 64'(e.replacements), 64'(got.replacements));
        compare_field("invalidate_count", 64'(e.invalidations), 64'(got.invalidations));
    endfunction

    function void close_out();
        while (awaited.size() != 0) begin
            failures++;
            $display("%0t missing beat: expected outcome %0d, got nothing",
                     $time, awaited[0].outcome);
            void'(awaited.pop_front());
        end
    endfunction
endclass

module tb;
    localparam int POOL_SIZE       = 32;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam logic [VA_BITS-1:0] USER_TOP = VA_BITS'(LIMIT_RESET);
    localparam logic [LIM_W-1:0]   LIMIT_MAX = LIM_W'(1) << VA_BITS;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [LIM_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind;
    logic [VA_BITS-1:0]    i_address;
    logic [LIM_W-1:0]      i_end_address;
    logic [FRAME_BITS-1:0] i_frame_number;
    logic [PROT_W-1:0]     i_protection;
    logic [FLAG_W-1:0]     i_page_flags;
    logic                  i_frame_resident;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [OUT_W-1:0]      o_outcome;
    logic [FRAME_BITS-1:0] o_hit_frame;
    logic [PROT_W-1:0]     o_hit_protection;
    logic [FLAG_W-1:0]     o_hit_flags;
    logic [CTR_W-1:0]      o_hit_count;
    logic [CTR_W-1:0]      o_miss_count;
    logic [CTR_W-1:0]      o_replace_count;
    logic [CTR_W-1:0]      o_invalidate_count;

    t_tlb_scoreboard  sb;
    logic [TAG_W-1:0] page_pool [POOL_SIZE];
    int               burst_left = 0;
    bit               hold_off_req = 1'b0;
    int               quiet_cycles = 0;

    direct_mapped_tlb_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_address          (i_address),
        .i_end_address      (i_end_address),
        .i_frame_number     (i_frame_number),
        .i_protection       (i_protection),
        .i_page_flags       (i_page_flags),
        .i_frame_resident   (i_frame_resident),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_outcome          (o_outcome),
        .o_hit_frame        (o_hit_frame),
        .o_hit_protection   (o_hit_protection),
        .o_hit_flags        (o_hit_flags),
        .o_hit_count        (o_hit_count),
        .o_miss_count       (o_miss_count),
        .o_replace_count    (o_replace_count),
        .o_invalidate_count (o_invalidate_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_tlb_req make_request(logic [KIND_W-1:0] kind,
                                              logic [VA_BITS-1:0] addr,
                                              logic [LIM_W-1:0] end_addr,
                                              logic [FRAME_BITS-1:0] frame,
                                              logic [PROT_W-1:0] prot,
                                              logic [FLAG_W-1:0] flags,
                                              logic resident);
        t_tlb_req r;
        r.kind     = kind;
        r.addr     = addr;
        r.end_addr = end_addr;
        r.frame    = frame;
        r.prot     = prot;
        r.flags    = flags;
        r.resident = resident;
        return r;
    endfunction

    function automatic t_tlb_req random_request();
        t_tlb_req         r;
        int               roll;
        logic [TAG_W-1:0] pg;
        roll = $urandom_range(0, 99);
        pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
        r.addr = {pg, PAGE_SHIFT'($urandom)};
        if ($urandom_range(0, 15) == 0)
            r.addr = VA_BITS'({$urandom, $urandom});
        r.end_addr = LIM_W'({$urandom, $urandom});
        r.frame    = FRAME_BITS'($urandom);
        r.prot     = PROT_W'($urandom);
        r.flags    = FLAG_W'($urandom);
        r.resident = ($urandom_range(0, 99) < 80);
        if (roll < 40) begin
            r.kind = KIND_LOOKUP;
        end else if (roll < 68) begin
            r.kind = KIND_INSERT;
        end else if (roll < 78) begin
            r.kind = KIND_INVPG;
        end else if (roll < 91) begin
            r.kind = KIND_RANGE;
            if ($urandom_range(0, 3) == 0)
                r.addr = VA_BITS'($urandom_range(0, 1 << 20));
            case ($urandom_range(0, 7))
                0: r.end_addr = sb.user_limit;
                1: r.end_addr = LIM_W'(r.addr) - LIM_W'($urandom_range(0, 4096));
                2: ;
                default: r.end_addr = LIM_W'(r.addr) + LIM_W'($urandom_range(1, 1 << 20));
            endcase
        end else if (roll < 93) begin
            r.kind = KIND_FLUSH;
        end else begin
            r.kind = KIND_W'($urandom_range(int'(KIND_FLUSH) + 1, (1 << KIND_W) - 1));
        end
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic send_req(input t_tlb_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= r.kind;
        i_address        <= r.addr;
        i_end_address    <= r.end_addr;
        i_frame_number   <= r.frame;
        i_protection     <= r.prot;
        i_page_flags     <= r.flags;
        i_frame_resident <= r.resident;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(r);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count, input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_off_req = 1'b1;
            send_req(random_request());
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    initial begin : stimulus
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_kind           = KIND_LOOKUP;
        i_address        = '0;
        i_end_address    = '0;
        i_frame_number   = '0;
        i_protection     = '0;
        i_page_flags     = '0;
        i_frame_resident = 1'b0;
        sb = new();
        // clustered low pages, pages crowding a few slots, and high pages
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < 16)
                page_pool[i] = TAG_W'($urandom_range(0, 255));
            else if (i < 28)
                page_pool[i] = TAG_W'({1'b0, 29'($urandom), 6'($urandom_range(0, 7))});
            else
                page_pool[i] = TAG_W'({1'b1, 29'($urandom), 6'($urandom)});
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_req(make_request(KIND_LOOKUP, '0, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_INSERT, '0, '0, '1, '1, '1, 1'b0));
        send_req(make_request(KIND_LOOKUP, '0, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_LOOKUP, 48'h123, '0, '0, '0, '0, 1'b0));
        send_req(make_request(KIND_LOOKUP, '0, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_INSERT, 48'h5000, '0, 28'h1, 8'h5a, 8'ha5, 1'b1));
        send_req(make_request(KIND_INSERT, 48'h45000, '0, 28'h2, 8'h01, 8'h80, 1'b1));
        send_req(make_request(KIND_INSERT, 48'h45000, '0, 28'h3, 8'h02, 8'h40, 1'b1));
        send_req(make_request(KIND_INVPG, 48'h5000, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_INVPG, 48'h45fff, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_INSERT, USER_TOP - 1'b1, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_LOOKUP, USER_TOP - 1'b1, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_LOOKUP, USER_TOP, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_INSERT, USER_TOP, '0, '1, '1, '1, 1'b1));
        send_req(make_request(KIND_INVPG, USER_TOP, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_LOOKUP, '1, '1, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_INSERT, 48'ha000, '0, 28'h77, 8'h3c, 8'hc3, 1'b1));
        send_req(make_request(KIND_RANGE, 48'h9000, 49'ha000, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_RANGE, 48'h9000, 49'ha001, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_RANGE, 48'h9000, 49'h9000, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_RANGE, '0, LIMIT_RESET + 1'b1, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_RANGE, '0, LIMIT_RESET, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_INSERT, 48'h3000, '0, 28'h5, 8'h0f, 8'hf0, 1'b1));
        send_req(make_request(KIND_FLUSH, '0, '0, '0, '0, '0, 1'b1));
        for (int k = int'(KIND_FLUSH) + 1; k < (1 << KIND_W); k++)
            send_req(make_request(KIND_W'(k), '0, '0, '0, '0, '0, 1'b1));

        run_random(500, 150);

        write_limit(LIMIT_MAX);
        send_req(make_request(KIND_INSERT, '1, '0, '1, '1, '1, 1'b1));
        send_req(make_request(KIND_LOOKUP, '1, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_RANGE, '0, LIMIT_MAX, '0, '0, '0, 1'b1));
        run_random(250, -1);

        write_limit(LIM_W'(1));
        send_req(make_request(KIND_INSERT, '0, '0, 28'h9, 8'h11, 8'h22, 1'b1));
        send_req(make_request(KIND_LOOKUP, '0, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_LOOKUP, 48'h1, '0, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_RANGE, '0, 49'h2, '0, '0, '0, 1'b1));
        send_req(make_request(KIND_RANGE, '0, 49'h1, '0, '0, '0, 1'b1));
        run_random(30, -1);

        write_limit(LIMIT_MAX - 1'b1);
        run_random(150, -1);

        write_limit(LIM_W'({$urandom_range(1, 200), PAGE_SHIFT'($urandom)}));
        run_random(150, -1);

        drain();
        repeat (ENTRIES + 16) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : result_stall
        int mode;
        int cyc;
        mode = 0;
        cyc  = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 97 == 0)
                mode = $urandom_range(0, 3);
            if (hold_off_req) begin
                // long hold-off so the block backs up into its request side
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 9) < 7);
                    default: i_out_stall <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(t_tlb_rsp'{o_outcome, o_hit_frame, o_hit_protection, o_hit_flags,
                                       o_hit_count, o_miss_count, o_replace_count,
                                       o_invalidate_count});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end
endmodule
